### rtl/csc_pkg.sv
`timescale 1ns / 1ps
package csc_pkg;

    localparam int NUM_VERTICES_DEF = 1024;
    localparam int MAX_NONZEROS_DEF = 16384;

    localparam logic [1:0] FUNC_LOAD_PTR = 2'd0;
    localparam logic [1:0] FUNC_LOAD_ROW = 2'd1;
    localparam logic [1:0] FUNC_SCATTER  = 2'd2;
    localparam logic [1:0] FUNC_READ     = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [10:0]        column;
        logic [9:0]         row;
        logic [14:0]        entry;
        logic signed [31:0] value;
        logic signed [31:0] weight;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [13:0]        hit_entry;
        logic signed [31:0] entry_value;
        logic               saturated;
        logic               patch_done;
    } t_out_item;

endpackage

### rtl/csc_sparse_scatter_accumulate_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        input      i_in_valid/o_in_stall  t_in_item
// out       output     o_out_valid/i_out_stall t_out_item
// Items are worked one at a time; the next item can be accepted in the cycle after the result
// is registered. A load writes its store and a read fetches the entry. A scatter-add reads the
// column pointers, emits without a search if the column is out of range or empty, else does a
// binary search (up to 15 probes at full depth) and on a hit waits for the multiply-add.
// Reset is synchronous and active low; the stores are undefined until written.
// A stalled result waits in the output register while the next item is worked on.
module csc_sparse_scatter_accumulate_top #(
    parameter int NUM_VERTICES = csc_pkg::NUM_VERTICES_DEF,
    parameter int MAX_NONZEROS = csc_pkg::MAX_NONZEROS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  csc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output csc_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_NONZEROS);
    localparam int CW = $clog2(NUM_VERTICES + 1);
    localparam int PW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PTR0, S_PTR1, S_PTR2, S_SRCH, S_PROBE, S_CHECK, S_CHK2,
        S_MACW, S_READ, S_READ2, S_EMIT
    } t_state;

    t_state r_state;
    csc_pkg::t_in_item r_item;
    csc_pkg::t_out_item r_res;

    logic [14:0]        r_ptr_mem [NUM_VERTICES + 1];
    logic [9:0]         r_row_mem [MAX_NONZEROS];
    logic signed [31:0] r_sum_mem [MAX_NONZEROS];

    logic [14:0]        r_ptr_rd;
    logic [9:0]         r_row_rd;
    logic signed [31:0] r_sum_rd;
    logic [PW-1:0]      r_lo, r_hi, r_end;
    logic               r_mac_go;
    logic               w_mac_done, w_mac_sat;
    logic signed [31:0] w_mac_sum;

    logic [PW-1:0] w_mid;
    logic [PW-1:0] w_ptr_clip;
    logic          w_in_acc;
    logic          w_entry_ok;

    assign w_mid      = PW'((({1'b0, r_lo} + {1'b0, r_hi}) >> 1));
    assign w_ptr_clip = (32'(r_ptr_rd) > 32'(MAX_NONZEROS)) ? PW'(MAX_NONZEROS)
                                                           : PW'(r_ptr_rd);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_entry_ok = 32'(r_item.entry) < 32'(MAX_NONZEROS);
    assign o_in_stall = (r_state != S_IDLE);

    csc_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mac_go),
        .i_a    (r_item.value),
        .i_b    (r_item.weight),
        .i_acc  (r_sum_rd),
        .o_done (w_mac_done),
        .o_sum  (w_mac_sum),
        .o_sat  (w_mac_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_mac_go    <= 1'b0;
        end else begin
            r_mac_go <= (r_state == S_CHECK) && (r_row_rd == r_item.row);
            if (r_state == S_EMIT && (!o_out_valid || !i_out_stall))
                o_out_valid <= 1'b1;
            else if (o_out_valid && !i_out_stall)
                o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_item  <= i_in_data;
                        r_state <= S_PTR0;
                    end
                end
                S_PTR0: begin
                    r_res.found       <= 1'b0;
                    r_res.entry_value <= '0;
                    r_res.saturated   <= 1'b0;
                    r_res.patch_done  <= r_item.last;
                    r_res.hit_entry   <= (r_item.func == csc_pkg::FUNC_LOAD_ROW && w_entry_ok)
                                         ? 14'(r_item.entry) : '0;
                    case (r_item.func)
                        csc_pkg::FUNC_LOAD_PTR: begin
                            if (32'(r_item.column) <= 32'(NUM_VERTICES))
                                r_ptr_mem[CW'(r_item.column)] <= r_item.entry;
                            r_state <= S_EMIT;
                        end
                        csc_pkg::FUNC_LOAD_ROW: begin
                            if (w_entry_ok) begin
                                r_row_mem[AW'(r_item.entry)] <= r_item.row;
                                r_sum_mem[AW'(r_item.entry)] <= '0;
                            end
                            r_state <= S_EMIT;
                        end
                        csc_pkg::FUNC_SCATTER: begin
                            if (32'(r_item.column) < 32'(NUM_VERTICES)) begin
                                r_ptr_rd <= r_ptr_mem[CW'(r_item.column)];
                                r_state  <= S_PTR1;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                        default: begin
                            if (w_entry_ok) begin
                                r_sum_rd <= r_sum_mem[AW'(r_item.entry)];
                                r_state  <= S_READ;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                    endcase
                end
                S_PTR1: begin
                    r_lo     <= PW'(r_ptr_rd);
                    r_ptr_rd <= r_ptr_mem[CW'(32'(r_item.column) + 1)];
                    r_state  <= S_PTR2;
                end
                S_PTR2: begin
                    r_hi  <= w_ptr_clip;
                    r_end <= w_ptr_clip;
                    r_state <= (32'(r_lo) < 32'(w_ptr_clip)) ? S_SRCH : S_EMIT;
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_row_rd <= r_row_mem[AW'(w_mid)];
                        r_state  <= S_PROBE;
                    end else if (r_lo < r_end) begin
                        r_row_rd <= r_row_mem[AW'(r_lo)];
                        r_sum_rd <= r_sum_mem[AW'(r_lo)];
                        r_state  <= S_CHECK;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_PROBE: begin
                    if (r_row_rd < r_item.row)
                        r_lo <= w_mid + PW'(1);
                    else
                        r_hi <= w_mid;
                    r_state <= S_SRCH;
                end
                S_CHECK: begin
                    if (r_row_rd == r_item.row)
                        r_state <= S_MACW;
                    else
                        r_state <= S_EMIT;
                end
                S_MACW: begin
                    if (w_mac_done) begin
                        r_sum_mem[AW'(r_lo)] <= w_mac_sum;
                        r_res.found       <= 1'b1;
                        r_res.hit_entry   <= 14'(r_lo);
                        r_res.entry_value <= w_mac_sum;
                        r_res.saturated   <= w_mac_sat;
                        r_state <= S_EMIT;
                    end
                end
                S_READ: begin
                    r_res.found       <= 1'b1;
                    r_res.hit_entry   <= 14'(r_item.entry);
                    r_res.entry_value <= r_sum_rd;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_acc && r_state != S_IDLE))
        else $error("item accepted while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_PROBE && r_lo >= r_hi))
        else $error("probe with empty range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_MACW && r_lo >= r_end))
        else $error("hit beyond column end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mac_done && r_state != S_MACW))
        else $error("mac result not awaited");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

### rtl/csc_mac.sv
`timescale 1ns / 1ps
// Multiply, round to Q16.16 and saturating add.
// The result and o_done are registered from r_stage, which is registered from i_start.
// Besides the multiplier, the block holds the wide rounding and saturating-add adders.
module csc_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [31:0] i_acc,
    output logic               o_done,
    output logic signed [31:0] o_sum,
    output logic               o_sat
);

    logic signed [63:0] r_prod;
    logic signed [32:0] r_addend;
    logic               r_stage;
    logic signed [48:0] w_round;
    logic signed [49:0] w_sum;

    // Round half up: add 2^15 then floor shift.
    assign w_round = 49'(r_prod >>> 16) + 49'(r_prod[15]);
    assign w_sum   = 50'(w_round) + 50'(r_addend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            o_done  <= r_stage;
            if (i_start) begin
                r_prod   <= i_a * i_b;
                r_addend <= 33'(i_acc);
            end
            if (r_stage) begin
                if (w_sum > 50'sd2147483647) begin
                    o_sum <= 32'sh7fffffff;
                    o_sat <= 1'b1;
                end else if (w_sum < -50'sd2147483648) begin
                    o_sum <= 32'sh80000000;
                    o_sat <= 1'b1;
                end else begin
                    o_sum <= w_sum[31:0];
                    o_sat <= 1'b0;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> $past(r_stage))
        else $error("mac done without stage");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_sat |-> (o_sum == 32'sh7fffffff || o_sum == 32'sh80000000))
        else $error("mac saturation flag without a limit value");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !$isunknown(o_sum))
        else $error("mac result unknown");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int NV = csc_pkg::NUM_VERTICES_DEF;
    localparam int NZ = csc_pkg::MAX_NONZEROS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PATTERN_COLS = 48;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    csc_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    csc_pkg::t_out_item o_out_data;

    csc_sparse_scatter_accumulate_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Shadow copy of the matrix stores, with flags for what has been written.
    logic [14:0]        col_ptr  [0:NV];
    bit                 ptr_set  [0:NV];
    logic [9:0]         row_mem  [0:NZ-1];
    bit                 row_set  [0:NZ-1];
    logic signed [31:0] sum_mem  [0:NZ-1];

    csc_pkg::t_out_item expected_q[$];
    int  n_errors;
    int  cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver stall, with a long counted hold-off when recv_hold is loaded.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report(string name, longint exp_v, longint got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        csc_pkg::t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_data);
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_out_data.found !== exp_r.found)
                    report("found", exp_r.found, o_out_data.found);
                if (o_out_data.hit_entry !== exp_r.hit_entry)
                    report("hit_entry", exp_r.hit_entry, o_out_data.hit_entry);
                if (o_out_data.entry_value !== exp_r.entry_value)
                    report("entry_value", exp_r.entry_value, o_out_data.entry_value);
                if (o_out_data.saturated !== exp_r.saturated)
                    report("saturated", exp_r.saturated, o_out_data.saturated);
                if (o_out_data.patch_done !== exp_r.patch_done)
                    report("patch_done", exp_r.patch_done, o_out_data.patch_done);
            end
        end
    end

    function automatic csc_pkg::t_out_item apply_item(csc_pkg::t_in_item it);
        csc_pkg::t_out_item r;
        int lo, hi, stop, mid;
        longint prod, acc;
        r = '0;
        r.patch_done = it.last;
        case (it.func)
            csc_pkg::FUNC_LOAD_PTR: begin
                if (it.column <= NV) begin
                    col_ptr[it.column] = it.entry;
                    ptr_set[it.column] = 1'b1;
                end
            end
            csc_pkg::FUNC_LOAD_ROW: begin
                if (it.entry < NZ) begin
                    row_mem[it.entry] = it.row;
                    row_set[it.entry] = 1'b1;
                    sum_mem[it.entry] = '0;
                    r.hit_entry = it.entry[13:0];
                end
            end
            csc_pkg::FUNC_SCATTER: begin
                if (it.column < NV) begin
                    lo = int'(col_ptr[it.column]);
                    hi = int'(col_ptr[it.column + 1]);
                    if (hi > NZ) hi = NZ;
                    stop = hi;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (row_mem[mid] < it.row) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo < stop && row_mem[lo] == it.row) begin
                        // Exact Q32.32 product, rounded half up to Q16.16.
                        prod = (longint'(it.value) * longint'(it.weight) + 64'sd32768) >>> 16;
                        acc = longint'(sum_mem[lo]) + prod;
                        if (acc > 64'sd2147483647) begin
                            acc = 64'sd2147483647;
                            r.saturated = 1'b1;
                        end else if (acc < -64'sd2147483648) begin
                            acc = -64'sd2147483648;
                            r.saturated = 1'b1;
                        end
                        sum_mem[lo] = acc[31:0];
                        r.found = 1'b1;
                        r.hit_entry = lo[13:0];
                        r.entry_value = acc[31:0];
                    end
                end
            end
            default: begin
                if (it.entry < NZ) begin
                    r.found = 1'b1;
                    r.hit_entry = it.entry[13:0];
                    r.entry_value = sum_mem[it.entry];
                end
            end
        endcase
        return r;
    endfunction

    // True when a scatter-add into this column only touches written entries.
    function automatic bit column_searchable(int col);
        int lo, hi;
        if (col >= NV) return 1'b1;
        if (!ptr_set[col] || !ptr_set[col + 1]) return 1'b0;
        lo = int'(col_ptr[col]);
        hi = int'(col_ptr[col + 1]);
        if (hi > NZ) hi = NZ;
        for (int i = lo; i < hi; i++)
            if (!row_set[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(csc_pkg::t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(apply_item(it));
    endtask

    task automatic send_fields(logic [1:0] f, int col, int row, int ent,
                               logic [31:0] val, logic [31:0] wt, int lst);
        csc_pkg::t_in_item it;
        it.func = f;
        it.column = 11'(col);
        it.row = 10'(row);
        it.entry = 15'(ent);
        it.value = val;
        it.weight = wt;
        it.last = 1'(lst);
        send_item(it);
    endtask

    task automatic wait_empty();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'h0001_0000;
            2: return $urandom_range(32'h3_0000) - 32'h1_8000;
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic csc_pkg::t_in_item random_item();
        csc_pkg::t_in_item it;
        int r, lo, hi;
        forever begin
            it.value = rand_q16();
            it.weight = rand_q16();
            it.last = 1'($urandom_range(1));
            it.row = 10'($urandom_range(1023));
            it.column = $urandom_range(3) == 0 ? 11'($urandom_range(2047))
                                               : 11'($urandom_range(PATTERN_COLS));
            it.entry = $urandom_range(3) == 0 ? 15'($urandom_range(32767))
                                              : 15'($urandom_range(260));
            r = $urandom_range(99);
            if (r < 5) begin
                it.func = csc_pkg::FUNC_LOAD_PTR;
                return it;
            end else if (r < 12) begin
                it.func = csc_pkg::FUNC_LOAD_ROW;
                return it;
            end else if (r < 25) begin
                it.func = csc_pkg::FUNC_READ;
                if (it.entry >= NZ || row_set[it.entry]) return it;
            end else begin
                it.func = csc_pkg::FUNC_SCATTER;
                if (column_searchable(it.column)) begin
                    if (it.column < NV && $urandom_range(3) != 0) begin
                        lo = int'(col_ptr[it.column]);
                        hi = int'(col_ptr[it.column + 1]);
                        if (hi > NZ) hi = NZ;
                        if (lo < hi) it.row = row_mem[$urandom_range(hi - 1, lo)];
                    end
                    return it;
                end
            end
        end
    endfunction

    // Loads a well-formed pattern: sorted distinct rows in each small column.
    task automatic load_pattern();
        int base, k, rw;
        base = $urandom_range(20);
        for (int c = 0; c <= PATTERN_COLS; c++) begin
            send_fields(csc_pkg::FUNC_LOAD_PTR, c, 0, base, 0, 0, 0);
            if (c == PATTERN_COLS) break;
            k = $urandom_range(5);
            rw = $urandom_range(40);
            for (int j = 0; j < k; j++) begin
                send_fields(csc_pkg::FUNC_LOAD_ROW, 0, rw, base + j, 0, 0,
                            (j == k - 1) ? 1 : 0);
                rw += 1 + $urandom_range(200);
            end
            base += k;
        end
    endtask

    task automatic test_directed();
        send_fields(csc_pkg::FUNC_LOAD_PTR, 1022, 0, 16380, 0, 0, 0);
        send_fields(csc_pkg::FUNC_LOAD_PTR, 1023, 0, 16380, 0, 0, 0);
        // End pointer past the store is clipped.
        send_fields(csc_pkg::FUNC_LOAD_PTR, 1024, 0, 20000, 0, 0, 0);
        send_fields(csc_pkg::FUNC_LOAD_PTR, 1500, 0, 32767, 0, 0, 1);
        send_fields(csc_pkg::FUNC_LOAD_ROW, 0, 0, 16380, 0, 0, 0);
        send_fields(csc_pkg::FUNC_LOAD_ROW, 0, 5, 16381, 0, 0, 0);
        send_fields(csc_pkg::FUNC_LOAD_ROW, 0, 512, 16382, 0, 0, 0);
        send_fields(csc_pkg::FUNC_LOAD_ROW, 0, 1023, 16383, 0, 0, 1);
        send_fields(csc_pkg::FUNC_LOAD_ROW, 0, 1023, 30000, 0, 0, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1023, 1023, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1023, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1023, 5, 0, 32'h0001_0000, 32'h0001_0000, 0);
        // Rounding exactly at one half, both signs.
        send_fields(csc_pkg::FUNC_SCATTER, 1023, 512, 0, 32'h0000_0001, 32'h0000_8000, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1023, 512, 0, 32'hFFFF_FFFF, 32'h0000_8000, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1023, 6, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1022, 5, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 2047, 5, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_fields(csc_pkg::FUNC_SCATTER, 1024, 5, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_fields(csc_pkg::FUNC_READ, 0, 0, 16383, 0, 0, 1);
        send_fields(csc_pkg::FUNC_READ, 0, 0, 16380, 0, 0, 0);
        send_fields(csc_pkg::FUNC_READ, 0, 0, 20000, 0, 0, 1);
        wait_empty();
    endtask

    task automatic test_random(int snd, int rcv, int n_items);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        load_pattern();
        for (int i = 0; i < n_items; i++) send_item(random_item());
        wait_empty();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 400;
        for (int i = 0; i < 30; i++) send_item(random_item());
        // Sender holds off until every result is back.
        wait_empty();
        for (int i = 0; i < 20; i++) send_item(random_item());
        wait_empty();
    endtask

    initial begin
        n_errors = 0;
        cycles = 0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(14, 70, 200);
        test_random(70, 14, 200);
        test_random(0, 0, 200);
        test_backpressure();

        repeat (100) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
